// ===== rtl/rdmc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdmc_pkg
// Shared codes, widths and types of the maze carver.
// ----------------------------------------------------------------------------
package rdmc_pkg;

    // Field widths of the request and result channels
    localparam int OP_W     = 1;
    localparam int RND_W    = 16;
    localparam int COORD_W  = 6;
    localparam int WALL_W   = 3;
    localparam int KIND_W   = 2;
    localparam int COUNT_W  = 13;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int GRID_W    = 7;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [GRID_W-1:0]    grid_t;
    typedef logic [OP_W-1:0]      op_t;
    typedef logic [WALL_W-1:0]    wall_t;
    typedef logic [KIND_W-1:0]    kind_t;

    localparam cfg_idx_t REG_GRID_ROWS = 2'd0;
    localparam cfg_idx_t REG_GRID_COLS = 2'd1;
    localparam grid_t    GRID_RESET    = 7'd16;

    localparam op_t OP_RESTART = 1'b0;
    localparam op_t OP_STEP    = 1'b1;

    localparam wall_t WALL_UP    = 3'd0;
    localparam wall_t WALL_DOWN  = 3'd1;
    localparam wall_t WALL_LEFT  = 3'd2;
    localparam wall_t WALL_RIGHT = 3'd3;
    localparam wall_t WALL_NONE  = 3'd4;

    localparam kind_t KIND_CARVED    = 2'd0;
    localparam kind_t KIND_BACKTRACK = 2'd1;
    localparam kind_t KIND_FINISHED  = 2'd2;
    localparam kind_t KIND_RESTARTED = 2'd3;

endpackage

// ===== rtl/rdmc_ram.sv =====
// ----------------------------------------------------------------------------
// rdmc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rdmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/random_dfs_maze_carver.sv =====
// ----------------------------------------------------------------------------
// random_dfs_maze_carver
// Randomised depth-first maze carver over a grid of up to MAX_ROWS x MAX_COLS
// cells; visited map and path stack each sit in a RAM.
//
//   channel | direction | handshake            | payload
//   s_      | in        | s_valid / s_ready    | operation, random_word
//   m_      | out       | m_valid / m_ready    | from/to cell, wall, kind, count
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A step reads the four neighbours in turn through the single read port of
// the visited map (ST_SCAN), decides in ST_DECIDE and loads the output
// register in ST_DONE; a backtrack adds ST_POP_RD and ST_POP_DATA for the
// stack read and its data. The next request is taken the cycle after ST_DONE.
// A restart, and reset, sweep the visited map one entry a cycle, all
// MAX_ROWS*MAX_COLS entries, during which no request is taken.
// A stalled result holds in the output register; the next request is taken
// meanwhile, but its result waits until the register is free.
// ----------------------------------------------------------------------------
module random_dfs_maze_carver
    import rdmc_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_operation,
    input  logic [RND_W-1:0]     s_random_word,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COORD_W-1:0]   m_from_row,
    output logic [COORD_W-1:0]   m_from_col,
    output logic [WALL_W-1:0]    m_opened_wall,
    output logic [COORD_W-1:0]   m_to_row,
    output logic [COORD_W-1:0]   m_to_col,
    output logic [KIND_W-1:0]    m_step_kind,
    output logic [COUNT_W-1:0]   m_cells_visited,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GRID_W-1:0]    cfg_data
);

    localparam int NUM_CELLS = MAX_ROWS * MAX_COLS;
    localparam int CELL_W    = $clog2(NUM_CELLS);
    localparam int TOT_W     = $clog2(NUM_CELLS + 1);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int RDIM_W    = $clog2(MAX_ROWS + 1);
    localparam int CDIM_W    = $clog2(MAX_COLS + 1);
    localparam int RX_W      = ROW_W + 1;
    localparam int CX_W      = COL_W + 1;

    // Neighbour order: down, up, right, left
    localparam wall_t NB_WALL [4] = '{WALL_DOWN, WALL_UP, WALL_RIGHT, WALL_LEFT};

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_DECIDE,
        ST_POP_RD,
        ST_POP_DATA,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [CELL_W-1:0]  clr_cnt_reg;
    logic [2:0]         scan_cnt_reg;
    logic [ROW_W-1:0]   cur_row_reg;
    logic [COL_W-1:0]   cur_col_reg;
    logic [TOT_W-1:0]   depth_reg;
    logic [TOT_W-1:0]   total_reg;
    grid_t              grid_rows_reg;
    grid_t              grid_cols_reg;
    logic [RND_W-1:0]   rnd_reg;
    logic [1:0]         rnd_mod3_reg;
    logic [3:0]         free_reg;
    logic [ROW_W-1:0]   from_row_reg;
    logic [COL_W-1:0]   from_col_reg;
    wall_t              wall_reg;
    kind_t              kind_reg;

    logic               m_valid_reg;
    logic [COORD_W-1:0] m_from_row_reg;
    logic [COORD_W-1:0] m_from_col_reg;
    wall_t              m_opened_wall_reg;
    logic [COORD_W-1:0] m_to_row_reg;
    logic [COORD_W-1:0] m_to_col_reg;
    kind_t              m_step_kind_reg;
    logic [COUNT_W-1:0] m_cells_visited_reg;

    // RAM ports
    logic                     vis_wr_en;
    logic [CELL_W-1:0]        vis_wr_addr;
    logic [0:0]               vis_wr_data;
    logic [CELL_W-1:0]        vis_rd_addr;
    logic [0:0]               vis_rd_data;
    logic                     stk_wr_en;
    logic [ROW_W+COL_W-1:0]   stk_rd_data;

    logic [RDIM_W-1:0]  rows_eff;
    logic [CDIM_W-1:0]  cols_eff;
    logic [RX_W-1:0]    row_x, rows_x;
    logic [CX_W-1:0]    col_x, cols_x;
    logic [3:0]         in_bounds;
    logic [ROW_W-1:0]   nb_row [4];
    logic [COL_W-1:0]   nb_col [4];
    logic [1:0]         pick_k;
    logic [1:0]         sel;
    logic [1:0]         scan_prev;
    logic               clearing;
    logic               carve;
    logic               out_free;

    function automatic logic [1:0] mod3(input logic [RND_W-1:0] x);
        logic [4:0] s;
        logic [2:0] t;
        logic [1:0] r;
        s = '0;
        // base-4 digit sum keeps the residue mod 3
        for (int i = 0; i < RND_W / 2; i++) begin
            s = s + 5'(x[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        case (t)
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4, 3'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return CELL_W'(r) * CELL_W'(MAX_COLS) + CELL_W'(c);
    endfunction

    // Effective grid size: zero counts as one, oversize clamps to the maximum
    always_comb begin
        if (grid_rows_reg == '0) begin
            rows_eff = RDIM_W'(1);
        end else if (32'(grid_rows_reg) > MAX_ROWS) begin
            rows_eff = RDIM_W'(MAX_ROWS);
        end else begin
            rows_eff = RDIM_W'(grid_rows_reg);
        end
        if (grid_cols_reg == '0) begin
            cols_eff = CDIM_W'(1);
        end else if (32'(grid_cols_reg) > MAX_COLS) begin
            cols_eff = CDIM_W'(MAX_COLS);
        end else begin
            cols_eff = CDIM_W'(grid_cols_reg);
        end
    end

    // Neighbours and their bounds; the current cell may lie outside a shrunk grid
    always_comb begin
        row_x  = RX_W'(cur_row_reg);
        col_x  = CX_W'(cur_col_reg);
        rows_x = RX_W'(rows_eff);
        cols_x = CX_W'(cols_eff);

        in_bounds[0] = (row_x + RX_W'(1) < rows_x) && (col_x < cols_x);
        in_bounds[1] = (cur_row_reg != '0) && (row_x - RX_W'(1) < rows_x)
                       && (col_x < cols_x);
        in_bounds[2] = (row_x < rows_x) && (col_x + CX_W'(1) < cols_x);
        in_bounds[3] = (cur_col_reg != '0) && (row_x < rows_x)
                       && (col_x - CX_W'(1) < cols_x);

        nb_row[0] = cur_row_reg + ROW_W'(1);
        nb_col[0] = cur_col_reg;
        nb_row[1] = cur_row_reg - ROW_W'(1);
        nb_col[1] = cur_col_reg;
        nb_row[2] = cur_row_reg;
        nb_col[2] = cur_col_reg + COL_W'(1);
        nb_row[3] = cur_row_reg;
        nb_col[3] = cur_col_reg - COL_W'(1);
    end

    // Choose the k-th free neighbour
    always_comb begin
        logic [2:0] seen;
        logic       found;
        seen  = '0;
        found = 1'b0;
        sel   = 2'd0;
        case ($countones(free_reg))
            2:       pick_k = {1'b0, rnd_reg[0]};
            3:       pick_k = rnd_mod3_reg;
            4:       pick_k = rnd_reg[1:0];
            default: pick_k = 2'd0;
        endcase
        for (int i = 0; i < 4; i++) begin
            if (free_reg[i] && !found) begin
                if (seen == 3'(pick_k)) begin
                    sel   = 2'(i);
                    found = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end
    end

    assign scan_prev = 2'(scan_cnt_reg - 3'd1);
    assign clearing  = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
    assign carve     = (state_reg == ST_DECIDE) && (free_reg != '0);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        vis_wr_en   = clearing || carve;
        vis_wr_addr = clearing ? clr_cnt_reg : cell_addr(nb_row[sel], nb_col[sel]);
        // cell 0,0 starts visited
        vis_wr_data = clearing ? 1'(clr_cnt_reg == '0) : 1'b1;
        vis_rd_addr = cell_addr(nb_row[scan_cnt_reg[1:0]], nb_col[scan_cnt_reg[1:0]]);
        stk_wr_en   = carve && (depth_reg < TOT_W'(NUM_CELLS));
    end

    rdmc_ram #(
        .WIDTH (1),
        .DEPTH (NUM_CELLS)
    ) u_visited (
        .aclk    (aclk),
        .wr_en   (vis_wr_en),
        .wr_addr (vis_wr_addr),
        .wr_data (vis_wr_data),
        .rd_addr (vis_rd_addr),
        .rd_data (vis_rd_data)
    );

    rdmc_ram #(
        .WIDTH (ROW_W + COL_W),
        .DEPTH (NUM_CELLS)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (depth_reg[CELL_W-1:0]),
        .wr_data ({cur_row_reg, cur_col_reg}),
        .rd_addr (depth_reg[CELL_W-1:0]),
        .rd_data (stk_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            clr_cnt_reg   <= '0;
            scan_cnt_reg  <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            depth_reg     <= '0;
            total_reg     <= TOT_W'(1);
            grid_rows_reg <= GRID_RESET;
            grid_cols_reg <= GRID_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                    REG_GRID_COLS: grid_cols_reg <= cfg_data;
                    default: ;
                endcase
            end

            // in ST_DONE the output register reloads instead
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_INIT, ST_CLEAR: begin
                    if (clr_cnt_reg == CELL_W'(NUM_CELLS - 1)) begin
                        clr_cnt_reg <= '0;
                        state_reg   <= (state_reg == ST_CLEAR) ? ST_DONE : ST_IDLE;
                    end else begin
                        clr_cnt_reg <= clr_cnt_reg + CELL_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        from_row_reg <= cur_row_reg;
                        from_col_reg <= cur_col_reg;
                        rnd_reg      <= s_random_word;
                        wall_reg     <= WALL_NONE;
                        if (s_operation == OP_RESTART) begin
                            cur_row_reg <= '0;
                            cur_col_reg <= '0;
                            depth_reg   <= '0;
                            total_reg   <= TOT_W'(1);
                            kind_reg    <= KIND_RESTARTED;
                            state_reg   <= ST_CLEAR;
                        end else begin
                            scan_cnt_reg <= '0;
                            state_reg    <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // read for neighbour n issued at count n, data back at n+1
                    scan_cnt_reg <= scan_cnt_reg + 3'd1;
                    rnd_mod3_reg <= mod3(rnd_reg);
                    if (scan_cnt_reg != 3'd0) begin
                        free_reg[scan_prev] <= in_bounds[scan_prev] & ~vis_rd_data[0];
                    end
                    if (scan_cnt_reg == 3'd4) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (free_reg != '0) begin
                        if (depth_reg < TOT_W'(NUM_CELLS)) begin
                            depth_reg <= depth_reg + TOT_W'(1);
                        end
                        cur_row_reg <= nb_row[sel];
                        cur_col_reg <= nb_col[sel];
                        total_reg   <= total_reg + TOT_W'(1);
                        wall_reg    <= NB_WALL[sel];
                        kind_reg    <= KIND_CARVED;
                        state_reg   <= ST_DONE;
                    end else if (depth_reg != '0) begin
                        depth_reg <= depth_reg - TOT_W'(1);
                        kind_reg  <= KIND_BACKTRACK;
                        state_reg <= ST_POP_RD;
                    end else begin
                        kind_reg  <= KIND_FINISHED;
                        state_reg <= ST_DONE;
                    end
                end
                ST_POP_RD: begin
                    state_reg <= ST_POP_DATA;
                end
                ST_POP_DATA: begin
                    cur_row_reg <= stk_rd_data[ROW_W+COL_W-1:COL_W];
                    cur_col_reg <= stk_rd_data[COL_W-1:0];
                    state_reg   <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg         <= 1'b1;
                        m_from_row_reg      <= COORD_W'(from_row_reg);
                        m_from_col_reg      <= COORD_W'(from_col_reg);
                        m_opened_wall_reg   <= wall_reg;
                        m_to_row_reg        <= COORD_W'(cur_row_reg);
                        m_to_col_reg        <= COORD_W'(cur_col_reg);
                        m_step_kind_reg     <= kind_reg;
                        m_cells_visited_reg <= COUNT_W'(total_reg);
                        state_reg           <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_from_row      = m_from_row_reg;
    assign m_from_col      = m_from_col_reg;
    assign m_opened_wall   = m_opened_wall_reg;
    assign m_to_row        = m_to_row_reg;
    assign m_to_col        = m_to_col_reg;
    assign m_step_kind     = m_step_kind_reg;
    assign m_cells_visited = m_cells_visited_reg;

endmodule

// ===== rtl/rdmc_checker.sv =====
// ----------------------------------------------------------------------------
// rdmc_checker
// Port-level checks on the maze carver's result channel.
// ----------------------------------------------------------------------------
module rdmc_checker
    import rdmc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [COORD_W-1:0] m_from_row,
    input  logic [COORD_W-1:0] m_from_col,
    input  logic [WALL_W-1:0]  m_opened_wall,
    input  logic [COORD_W-1:0] m_to_row,
    input  logic [COORD_W-1:0] m_to_col,
    input  logic [KIND_W-1:0]  m_step_kind,
    input  logic [COUNT_W-1:0] m_cells_visited
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_to_row) && $stable(m_to_col)
                                && $stable(m_step_kind) && $stable(m_cells_visited))
        else $error("result changed while stalled");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_step_kind == KIND_RESTARTED |->
            m_to_row == '0 && m_to_col == '0 && m_cells_visited == COUNT_W'(1)
            && m_opened_wall == WALL_NONE)
        else $error("restart result malformed");

    a_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_step_kind == KIND_FINISHED |->
            m_to_row == m_from_row && m_to_col == m_from_col
            && m_opened_wall == WALL_NONE)
        else $error("finished result moved");

    // a carve moves to the neighbour behind the opened wall
    a_carve: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_step_kind == KIND_CARVED |->
            (m_opened_wall == WALL_DOWN && m_to_row == m_from_row + COORD_W'(1)
                && m_to_col == m_from_col)
            || (m_opened_wall == WALL_UP && m_to_row == m_from_row - COORD_W'(1)
                && m_to_col == m_from_col)
            || (m_opened_wall == WALL_RIGHT && m_to_col == m_from_col + COORD_W'(1)
                && m_to_row == m_from_row)
            || (m_opened_wall == WALL_LEFT && m_to_col == m_from_col - COORD_W'(1)
                && m_to_row == m_from_row))
        else $error("carve wall does not match move");

    a_backtrack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_step_kind == KIND_BACKTRACK |-> m_opened_wall == WALL_NONE)
        else $error("backtrack opened a wall");

endmodule

bind random_dfs_maze_carver rdmc_checker u_rdmc_checker (.*);
